/* rtl/assert_macros.svh */
// Assertion macros shared by the allocator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define GFBA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define GFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define GFBA_ASSERT(lbl, clk, rst_n, prop, msg)

`define GFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/gfba_pkg.sv */
// Shared types and codes of the grouped free block allocator.
`default_nettype none

package gfba_pkg;

	localparam logic KIND_ALLOC   = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		RES_FAIL,
		RES_POP,
		RES_LINK,
		RES_REL
	} res_kind_t;

	typedef enum logic {
		COPY_SPILL,
		COPY_RELOAD
	} copy_mode_t;

	typedef struct packed {
		logic       take;
		logic       push;
		logic       pop;
		logic       grab_link;
		logic       calc_base;
		logic       copy_start;
		logic       copy_step;
		logic       finish;
		copy_mode_t mode;
		logic       res_load;
		res_kind_t  res_kind;
	} cmd_t;

	typedef struct packed {
		logic stack_empty;
		logic stack_full;
		logic link_zero;
		logic block_ok;
		logic copy_last;
	} sts_t;

endpackage

`default_nettype wire

/* rtl/gfba_dp.sv */
// Datapath: link, cached stack, group store, free counter and result register.
`default_nettype none
`include "assert_macros.svh"

module gfba_dp
	import gfba_pkg::*;
#(
	parameter int NUM_BLOCKS  = 512,
	parameter int GROUP_WORDS = 50,
	localparam int BW = $clog2(NUM_BLOCKS),
	localparam int CW = $clog2(NUM_BLOCKS + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [BW-1:0] block,
	input  wire cmd_t          cmd,
	output sts_t               sts,
	output logic               status,
	output logic [BW-1:0]      granted_block,
	output logic [CW-1:0]      free_blocks
);

	localparam int IW = $clog2(GROUP_WORDS);
	localparam int SD = GROUP_WORDS - 1;
	localparam int AW = $clog2(SD);
	localparam int GD = NUM_BLOCKS * GROUP_WORDS;
	localparam int SW = $clog2(GD);

	logic [BW-1:0] link_q;
	logic [IW-1:0] count_q;
	logic [CW-1:0] free_q;
	logic [BW-1:0] blk_q;
	logic [BW-1:0] grant_q;
	logic [SW-1:0] base_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] idx_s1;
	logic          vld_s1;
	logic [BW-1:0] stack_rd_s1;
	logic [BW-1:0] grp_rd_s1;
	logic          status_q;
	logic [BW-1:0] granted_q;

	logic [BW-1:0] stack_mem [SD];
	logic [BW-1:0] grp_mem [GD];

	logic          st_we;
	logic [AW-1:0] st_wa;
	logic [BW-1:0] st_wd;
	logic [AW-1:0] st_ra;
	logic          grp_we;
	logic [SW-1:0] gw_addr;
	logic [SW-1:0] gr_addr;
	logic [BW-1:0] gw_data;
	logic [BW-1:0] base_src;
	logic [CW-1:0] free_nx;
	logic [BW-1:0] granted_nx;

	always_comb begin
		st_we = 1'b0;
		st_wa = '0;
		st_wd = grp_rd_s1;
		if (cmd.push) begin
			st_we = 1'b1;
			st_wa = AW'(count_q);
			st_wd = block;
		end else if (vld_s1 && cmd.mode == COPY_RELOAD && idx_s1 != '0) begin
			st_we = 1'b1;
			st_wa = AW'(idx_s1 - 1'b1);
		end
	end

	always_comb begin
		if (cmd.pop) begin
			st_ra = AW'(count_q - 1'b1);
		end else if (idx_q == '0) begin
			st_ra = '0;
		end else begin
			st_ra = AW'(idx_q - 1'b1);
		end
	end

	assign grp_we   = vld_s1 && cmd.mode == COPY_SPILL;
	assign gw_addr  = base_q + SW'(idx_s1);
	assign gr_addr  = base_q + SW'(idx_q);
	assign gw_data  = (idx_s1 == '0) ? link_q : stack_rd_s1;
	assign base_src = (cmd.mode == COPY_RELOAD) ? link_q : blk_q;

	always_comb begin
		free_nx    = free_q;
		granted_nx = '0;
		case (cmd.res_kind) inside
			RES_POP, RES_LINK: begin
				if (free_q != '0) begin
					free_nx = free_q - 1'b1;
				end
				granted_nx = (cmd.res_kind == RES_POP) ? stack_rd_s1 : grant_q;
			end
			RES_REL: begin
				if (free_q != CW'(NUM_BLOCKS)) begin
					free_nx = free_q + 1'b1;
				end
			end
			default: begin
				free_nx = free_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q  <= '0;
			count_q <= '0;
			free_q  <= '0;
			idx_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= cmd.copy_step;
			if (cmd.copy_start) begin
				idx_q <= '0;
			end else if (cmd.copy_step) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.push) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.pop) begin
				count_q <= count_q - 1'b1;
			end else if (cmd.finish) begin
				count_q <= (cmd.mode == COPY_RELOAD) ? IW'(GROUP_WORDS - 1) : '0;
			end
			if (cmd.finish && cmd.mode == COPY_SPILL) begin
				link_q <= blk_q;
			end else if (vld_s1 && cmd.mode == COPY_RELOAD && idx_s1 == '0) begin
				link_q <= grp_rd_s1;
			end
			if (cmd.res_load) begin
				free_q <= free_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			blk_q <= block;
		end
		if (cmd.grab_link) begin
			grant_q <= link_q;
		end
		if (cmd.calc_base) begin
			base_q <= SW'(base_src) * SW'(GROUP_WORDS);
		end
		idx_s1 <= idx_q;
		if (st_we) begin
			stack_mem[st_wa] <= st_wd;
		end
		stack_rd_s1 <= stack_mem[st_ra];
		if (grp_we) begin
			grp_mem[gw_addr] <= gw_data;
		end
		grp_rd_s1 <= grp_mem[gr_addr];
		if (cmd.res_load) begin
			status_q  <= (cmd.res_kind == RES_FAIL);
			granted_q <= granted_nx;
		end
	end

	assign sts.stack_empty = (count_q == '0);
	assign sts.stack_full  = (count_q == IW'(GROUP_WORDS - 1));
	assign sts.link_zero   = (link_q == '0);
	assign sts.block_ok    = (block != '0) && ({1'b0, block} < (BW + 1)'(NUM_BLOCKS));
	assign sts.copy_last   = (idx_q == IW'(GROUP_WORDS - 1));

	assign status        = status_q;
	assign granted_block = granted_q;
	assign free_blocks   = free_q;

	`GFBA_ASSERT(a_count_range, clk, arst_n, count_q <= IW'(GROUP_WORDS - 1),
		"stack count beyond capacity")
	`GFBA_ASSERT(a_push_room, clk, arst_n, !(cmd.push && sts.stack_full),
		"push into a full stack")
	`GFBA_ASSERT(a_pop_data, clk, arst_n, !(cmd.pop && sts.stack_empty),
		"pop from an empty stack")

endmodule

`default_nettype wire

/* rtl/gfba_ctrl.sv */
// Controller: handshakes, operation decode and spill/reload sequencing.
`default_nettype none
`include "assert_macros.svh"

module gfba_ctrl
	import gfba_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire logic kind,
	output logic      out_valid,
	input  wire logic out_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_BASE,
		ST_COPY,
		ST_DRAIN
	} state_t;

	state_t     state_q;
	copy_mode_t mode_q;
	logic       out_valid_q;
	logic       accept;

	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.mode     = mode_q;
		cmd.res_kind = RES_FAIL;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.take = 1'b1;
					if (kind == KIND_ALLOC) begin
						if (!sts.stack_empty) begin
							cmd.pop = 1'b1;
						end else if (!sts.link_zero) begin
							cmd.grab_link = 1'b1;
						end else begin
							cmd.res_load = 1'b1;
						end
					end else if (!sts.block_ok) begin
						cmd.res_load = 1'b1;
					end else if (!sts.stack_full) begin
						cmd.push     = 1'b1;
						cmd.res_load = 1'b1;
						cmd.res_kind = RES_REL;
					end
				end
			end
			ST_POP: begin
				cmd.res_load = 1'b1;
				cmd.res_kind = RES_POP;
			end
			ST_BASE: begin
				cmd.calc_base  = 1'b1;
				cmd.copy_start = 1'b1;
			end
			ST_COPY: begin
				cmd.copy_step = 1'b1;
			end
			ST_DRAIN: begin
				cmd.finish   = 1'b1;
				cmd.res_load = 1'b1;
				cmd.res_kind = (mode_q == COPY_RELOAD) ? RES_LINK : RES_REL;
			end
			default: begin
				cmd.res_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= COPY_SPILL;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q <= (kind == KIND_ALLOC) ? COPY_RELOAD : COPY_SPILL;
						if (kind == KIND_ALLOC) begin
							if (!sts.stack_empty) begin
								state_q <= ST_POP;
							end else if (!sts.link_zero) begin
								state_q <= ST_BASE;
							end
						end else if (sts.block_ok && sts.stack_full) begin
							state_q <= ST_BASE;
						end
					end
				end
				ST_POP: begin
					state_q <= ST_IDLE;
				end
				ST_BASE: begin
					state_q <= ST_COPY;
				end
				ST_COPY: begin
					if (sts.copy_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`GFBA_ASSERT(a_load_free, clk, arst_n, !(cmd.res_load && out_valid_q && out_stall),
		"result loaded over a stalled beat")
	`GFBA_ASSERT_NEXT(a_copy_hold, clk, arst_n, state_q == ST_COPY && !sts.copy_last,
		state_q == ST_COPY, "group copy left early")
	`GFBA_ASSERT_NEXT(a_drain_res, clk, arst_n, state_q == ST_DRAIN,
		out_valid_q && state_q == ST_IDLE, "group copy ended without a result")

endmodule

`default_nettype wire

/* rtl/grouped_free_block_allocator.sv */
// Top level of the grouped free block allocator.
//
// Hands out and takes back block numbers through a Unix-style grouped free
// list: a cached stack of up to GROUP_WORDS-1 free blocks plus a link word,
// with full groups spilled into a group store indexed by the released block.
// One beat in, one result beat out, one operation in flight. A release that
// fits the stack, a rejected release and an allocate with nothing free give
// their result at the accepting edge; a plain allocate first registers the
// word read from the stack memory and loads its result from that register.
// A release onto a full stack (spill) or an allocate from an empty stack
// (reload) runs a group base multiply, then moves one word a cycle between
// the stack memory and the group store, then drains the copy pipeline. The
// next beat is taken once no operation is in flight and the result register
// is free or is being emptied. Neither memory is cleared after reset; a
// group is only read after it has been spilled.
`default_nettype none

module grouped_free_block_allocator
	import gfba_pkg::*;
#(
	parameter int NUM_BLOCKS  = 512,
	parameter int GROUP_WORDS = 50,
	localparam int BW = $clog2(NUM_BLOCKS),
	localparam int CW = $clog2(NUM_BLOCKS + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          kind,
	input  wire logic [BW-1:0] block,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic               status,
	output logic [BW-1:0]      granted_block,
	output logic [CW-1:0]      free_blocks
);

	cmd_t cmd;
	sts_t sts;

	gfba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	gfba_dp #(
		.NUM_BLOCKS  (NUM_BLOCKS),
		.GROUP_WORDS (GROUP_WORDS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.block         (block),
		.cmd           (cmd),
		.sts           (sts),
		.status        (status),
		.granted_block (granted_block),
		.free_blocks   (free_blocks)
	);

endmodule

`default_nettype wire
